>>> rtl/hed_pkg.sv
`default_nettype none

package hed_pkg;

  // Sizes of the pending buffer, the input queue and the entity table.
  localparam int unsigned PENDING_DEPTH = 5;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned NUM_SEQ       = 8;
  localparam int unsigned SEQ_MAX       = 6;

  // One input byte as it travels from the queue to the decoder engine.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hed_item_t;

  // Outcome of matching the held bytes against the entity table.
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_PREFIX,
    CLS_FULL
  } hed_kind_e;

  typedef struct packed {
    hed_kind_e  kind;
    logic [2:0] idx;
  } hed_cls_t;

  // Entity table: text, length and the first replacement byte.
  localparam logic [3:0] SEQ_LEN [NUM_SEQ] = '{
    4'd4, 4'd4, 4'd2, 4'd5, 4'd6, 4'd6, 4'd5, 4'd5
  };

  localparam logic [7:0] SEQ_TEXT [NUM_SEQ][SEQ_MAX] = '{
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"/", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"&", "a", "m", "p", ";", 8'h00},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "n", "b", "s", "p", ";"},
    '{"&", "#", "4", "3", ";", 8'h00},
    '{"&", "#", "3", "9", ";", 8'h00}
  };

  localparam logic [7:0] SEQ_REP [NUM_SEQ] = '{
    "<", ">", "\\", "&", "\"", " ", "+", "'"
  };

  // Only the slash-n pair produces a second byte, which is always this one.
  localparam logic SEQ_TWO [NUM_SEQ] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };
  localparam logic [7:0] SECOND_BYTE = "n";

  // Compare the first n held bytes with every entity. A full match wins;
  // otherwise the bytes are either a proper prefix of some entity or nothing.
  function automatic hed_cls_t hed_classify(input logic [SEQ_MAX-1:0][7:0] b,
                                            input logic [3:0] n);
    hed_cls_t r;
    logic     ok;
    r.kind = CLS_NONE;
    r.idx  = '0;
    for (int s = NUM_SEQ - 1; s >= 0; s--) begin
      ok = 1'b1;
      for (int i = 0; i < SEQ_MAX; i++) begin
        if ((4'(i) < n) && (4'(i) < SEQ_LEN[s]) && (b[i] != SEQ_TEXT[s][i])) begin
          ok = 1'b0;
        end
      end
      if (ok && (n == SEQ_LEN[s])) begin
        r.kind = CLS_FULL;
        r.idx  = 3'(s);
      end else if (ok && (n < SEQ_LEN[s]) && (r.kind != CLS_FULL)) begin
        r.kind = CLS_PREFIX;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hed_in_if.sv
`default_nettype none

// Input channel: one text byte per transfer.
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> rtl/hed_out_if.sv
`default_nettype none

// Output channel: one decoded byte per transfer.
interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> rtl/hed_queue.sv
`default_nettype none

module hed_queue
  import hed_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hed_in_if.sink     in_i,
  output hed_item_t  item_o,
  output logic       item_valid_o,
  input  wire logic  item_ready_i
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  hed_item_t          mem_q [Depth];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push, pop;

  // Handshakes on both sides of the queue.
  assign in_i.ready   = (cnt_q != CNT_W'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = item_valid_o && item_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: in_i.in_byte, last: in_i.in_last};
    end
  end

endmodule

`default_nettype wire

>>> rtl/hed_engine.sv
`default_nettype none

module hed_engine
  import hed_pkg::*;
#(
  parameter int unsigned PendingDepth = PENDING_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hed_item_t  item_i,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  hed_out_if.source       out_o
);

  localparam int unsigned WORK_N = PendingDepth + 1;
  localparam int unsigned IDX_W  = $clog2(WORK_N);
  localparam int unsigned CNT_W  = $clog2(WORK_N + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_SECOND
  } state_e;

  state_e                 state_q, state_d;
  logic [7:0]             work_q [WORK_N];
  logic [7:0]             work_d [WORK_N];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   last_q, last_d;
  logic                   ovalid_q, ovalid_d;
  logic [7:0]             obyte_q, obyte_d;
  logic                   olast_q, olast_d;
  logic [SEQ_MAX-1:0][7:0] win;
  hed_cls_t               cls;
  logic                   out_free;

  // The matcher looks at the oldest held bytes.
  always_comb begin
    for (int i = 0; i < SEQ_MAX; i++) begin
      win[i] = work_q[i];
    end
  end
  assign cls = hed_classify(win, 4'(cnt_q));

  assign out_free     = !ovalid_q || out_o.ready;
  assign item_ready_o = (state_q == ST_IDLE);

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.out_last = olast_q;

  // Sequencer: take a byte, then scan or flush held bytes, one step per unstalled cycle.
  always_comb begin
    state_d  = state_q;
    work_d   = work_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    ovalid_d = ovalid_q && !out_o.ready;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          work_d[cnt_q[IDX_W-1:0]] = item_i.data;
          cnt_d   = cnt_q + 1'b1;
          last_d  = item_i.last;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (cls.kind)
          CLS_FULL: begin
            if (out_free) begin
              ovalid_d = 1'b1;
              obyte_d  = SEQ_REP[cls.idx];
              olast_d  = last_q && !SEQ_TWO[cls.idx];
              cnt_d    = '0;
              state_d  = SEQ_TWO[cls.idx] ? ST_SECOND : ST_IDLE;
            end
          end
          CLS_PREFIX: begin
            // Hold the bytes, unless the text ends here.
            state_d = last_q ? ST_FLUSH : ST_IDLE;
          end
          default: begin
            if (out_free) begin
              ovalid_d = 1'b1;
              obyte_d  = work_q[0];
              olast_d  = last_q && (cnt_q == CNT_W'(1));
              for (int i = 0; i < WORK_N - 1; i++) begin
                work_d[i] = work_q[i + 1];
              end
              cnt_d = cnt_q - 1'b1;
              if (cnt_q == CNT_W'(1)) begin
                state_d = ST_IDLE;
              end
            end
          end
        endcase
      end
      ST_FLUSH: begin
        // End of text: the held bytes go out as they are.
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = work_q[0];
          olast_d  = (cnt_q == CNT_W'(1));
          for (int i = 0; i < WORK_N - 1; i++) begin
            work_d[i] = work_q[i + 1];
          end
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = SECOND_BYTE;
          olast_d  = last_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      ovalid_q <= 1'b0;
      obyte_q  <= '0;
      olast_q  <= 1'b0;
      for (int i = 0; i < WORK_N; i++) begin
        work_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      ovalid_q <= ovalid_d;
      obyte_q  <= obyte_d;
      olast_q  <= olast_d;
      work_q   <= work_d;
    end
  end

  // While waiting for a byte, the held bytes always fit the pending buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q <= CNT_W'(PendingDepth)))
    else $error("pending buffer holds more bytes than it can");

  // Once a final byte has been handled, nothing is left pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && last_q) |-> (cnt_q == '0))
    else $error("bytes left pending after the end of the text");

  // Flushing only happens at the end of the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (last_q && cnt_q != '0))
    else $error("flush without an end of text");

  // A scan step always has at least one byte to work on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SECOND) |->
      ((state_q == ST_SCAN) == (cnt_q != '0)))
    else $error("scan state and byte count disagree");

endmodule

`default_nettype wire

>>> rtl/html_entity_decoder.sv
// Streaming decoder for a fixed set of HTML character entities.
// Input channel in_i carries one text byte per transfer with in_last set on
// the final byte; output channel out_o carries the decoded bytes, with
// out_last set on the final output byte that a final input byte causes.
// &lt; &gt; &amp; &quot; &nbsp; &#43; &#39; are replaced by their character,
// and slash-n becomes backslash-n. Bytes that may still start an entity are
// held back; when a partial match fails the oldest held byte goes out as is
// and the rest are matched again. At the end of the text all held bytes are
// sent out unchanged.
// Input bytes first enter a two-entry queue, so up to two bytes can be
// accepted while the decoder works. The decoder takes no new byte until it
// is done with the last one: it loads the byte, then makes one matcher
// decision or sends one output byte per step, and a byte that ends a failed
// match sends out each held byte in turn. Each byte passes through the
// queue, the pending buffer and the output register before it is presented.
// Reset empties the queue and the pending buffer and drops any output not
// yet transferred. When the receiver stalls, the output register holds its
// byte, the decoder waits, and the queue fills before in_i.ready falls.
`default_nettype none

module html_entity_decoder
  import hed_pkg::*;
#(
  parameter int unsigned PendingDepth = PENDING_DEPTH,
  parameter int unsigned QueueDepth   = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hed_in_if.sink    in_i,
  hed_out_if.source out_o
);

  hed_item_t item;
  logic      item_valid;
  logic      item_ready;

  // Front: accepts bytes and buffers them.
  hed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Back: entity matching and output.
  hed_engine #(
    .PendingDepth (PendingDepth)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
module testbench
  import hed_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ENTITIES = 8;
  localparam int unsigned RANDOM_BYTES = 380;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned IDLE_PERCENT = 29;

  logic clk_i;
  logic rst_ni;

  hed_in_if  in_if ();
  hed_out_if out_if ();

  html_entity_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Entity texts and what each one turns into.
  string entity_text [NUM_ENTITIES] = '{
    "&lt;", "&gt;", "/n", "&amp;", "&quot;", "&nbsp;", "&#43;", "&#39;"
  };
  string entity_repl [NUM_ENTITIES] = '{
    "<", ">", "\\n", "&", "\"", " ", "+", "'"
  };

  hed_item_t   text_q[$];
  hed_item_t   decoded_q[$];
  logic [7:0]  held_q[$];
  hed_item_t   drive_item;
  hed_item_t   want;
  int unsigned text_total;
  int unsigned sent_count;
  int unsigned got_count;
  int unsigned error_count;
  int unsigned quiet_cycles;

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Match the held bytes from position first against the entity table.
  function automatic hed_kind_e match_held(input logic [7:0] w[$], input int unsigned first,
                                           output int unsigned which);
    int unsigned span;
    int unsigned len;
    bit          same;
    hed_kind_e   kind;
    kind  = CLS_NONE;
    which = 0;
    span  = w.size() - first;
    for (int s = 0; s < NUM_ENTITIES; s++) begin
      len  = entity_text[s].len();
      same = (span <= len);
      for (int i = 0; i < span && same; i++) begin
        if (w[first + i] != entity_text[s][i]) begin
          same = 1'b0;
        end
      end
      if (same && span == len) begin
        which = s;
        return CLS_FULL;
      end
      if (same) begin
        kind = CLS_PREFIX;
      end
    end
    return kind;
  endfunction

  // Decode one accepted byte and queue the bytes it releases.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]  work[$];
    hed_item_t   outs[$];
    int unsigned n;
    int unsigned first;
    int unsigned which;
    hed_kind_e   kind;
    work = held_q;
    work.insert(work.size(), b);
    n     = work.size();
    first = 0;
    while (first < n) begin
      kind = match_held(work, first, which);
      if (kind == CLS_FULL) begin
        for (int i = 0; i < entity_repl[which].len(); i++) begin
          outs.insert(outs.size(), '{data: entity_repl[which][i], last: 1'b0});
        end
        first = n;
      end else if (kind == CLS_PREFIX) begin
        break;
      end else begin
        outs.insert(outs.size(), '{data: work[first], last: 1'b0});
        first++;
      end
    end
    // At the end of the text everything held goes out as is.
    if (last) begin
      while (first < n) begin
        outs.insert(outs.size(), '{data: work[first], last: 1'b0});
        first++;
      end
    end else begin
      while (n - first > PENDING_DEPTH) begin
        outs.insert(outs.size(), '{data: work[first], last: 1'b0});
        first++;
      end
    end
    held_q.delete();
    for (int i = first; i < n; i++) begin
      held_q.insert(held_q.size(), work[i]);
    end
    if (last && outs.size() != 0) begin
      outs[outs.size() - 1].last = 1'b1;
    end
    foreach (outs[i]) begin
      decoded_q.insert(decoded_q.size(), outs[i]);
    end
  endtask

  function automatic void push_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), '{data: b, last: 1'b0});
  endfunction

  function automatic void add_bytes(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endfunction

  function automatic void close_text();
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  // A text of mostly whole entities and entity fragments, with some noise.
  task automatic add_random_text();
    int unsigned tokens;
    int unsigned e;
    int unsigned cut;
    int unsigned pick;
    string       lure;
    lure   = "&;/nt#3";
    tokens = $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      e    = $urandom_range(0, NUM_ENTITIES - 1);
      if (pick < 40) begin
        add_bytes(entity_text[e]);
      end else if (pick < 60) begin
        cut = $urandom_range(1, entity_text[e].len() - 1);
        for (int i = 0; i < cut; i++) begin
          push_byte(entity_text[e][i]);
        end
      end else if (pick < 80) begin
        push_byte(lure[$urandom_range(0, lure.len() - 1)]);
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    close_text();
  endtask

  // Input driver: presents the next queued byte unless it idles this cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.in_byte, in_if.in_last);
        sent_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (text_q.size() != 0 &&
            ((sent_count >= 150 && sent_count < 260) ||
             $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          drive_item = text_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= drive_item.data;
          in_if.in_last <= drive_item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transfer against the oldest decoded byte.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_count++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h last %b",
                                    out_if.out_byte, out_if.out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_if.out_byte !== want.data) begin
            report_mismatch($sformatf("byte %h, expected %h", out_if.out_byte, want.data));
          end
          if (out_if.out_last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b on byte %h",
                                      out_if.out_last, want.last, want.data));
          end
        end
      end
      out_if.ready <= (got_count >= 150 && got_count < 260) ||
                      ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    sent_count    = 0;
    got_count     = 0;
    error_count   = 0;
    quiet_cycles  = 0;

    // Overlapping start, slash-n after a stray slash, and a zero byte at the end.
    add_bytes("&&lt;//n");
    push_byte(8'h00);
    close_text();
    // Text that ends inside an entity, so the held bytes are flushed.
    add_bytes("&quo");
    close_text();
    // A one-byte text with all bits set.
    push_byte(8'hFF);
    close_text();
    // Failed numeric entity followed by a whole one.
    add_bytes("&#3x&amp;");
    close_text();
    while (text_q.size() < RANDOM_BYTES) begin
      add_random_text();
    end
    text_total = text_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every byte to go in and every decoded byte to come out.
    while (sent_count < text_total || decoded_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hed_pkg.sv
rtl/hed_in_if.sv
rtl/hed_out_if.sv
rtl/hed_queue.sv
rtl/hed_engine.sv
rtl/html_entity_decoder.sv
dv/testbench.sv
